// ===== src/rpd_pkg.sv =====
// Shared types, codes and code-mapping functions for the response packet deframer.
package rpd_pkg;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_BADHDR  = 2'd2;

	localparam logic [1:0] TYPE_REGULAR = 2'd0;
	localparam logic [1:0] TYPE_INFO    = 2'd1;
	localparam logic [1:0] TYPE_UNKNOWN = 2'd2;

	localparam logic [3:0] CODE_OK          = 4'd0;
	localparam logic [3:0] CODE_APPCORRUPT  = 4'd9;
	localparam logic [3:0] CODE_TIMEOUT     = 4'd10;
	localparam logic [3:0] CODE_UNKNOWN     = 4'd11;
	localparam logic [3:0] CODE_UNKNOWNRESP = 4'd12;
	localparam logic [3:0] CODE_BADMSG      = 4'd6;
	localparam logic [3:0] CODE_INVALID     = 4'd13;

	localparam logic [1:0] INFO_EMIT    = 2'd0;
	localparam logic [1:0] INFO_DATA    = 2'd1;
	localparam logic [1:0] INFO_INVALID = 2'd2;

	localparam logic [7:0] SYNC_BYTE     = 8'hFF;
	localparam logic [7:0] REGULAR_BYTE  = 8'hFF;
	localparam logic [7:0] INFO_BYTE     = 8'hFE;
	localparam logic [7:0] RAW_APPCORRUPT  = 8'd52;
	localparam logic [7:0] RAW_UNKNOWN     = 8'd53;
	localparam logic [7:0] RAW_UNKNOWNRESP = 8'd254;
	localparam logic [7:0] RAW_TIMEOUT     = 8'd255;
	localparam logic [7:0] RAW_LAST_PLAIN  = 8'd8;
	localparam logic [7:0] RAW_INFO_EMIT   = 8'd6;
	localparam logic [7:0] RAW_INFO_DATA   = 8'd3;

	localparam logic [8:0] POS_FIRST  = 9'd0;
	localparam logic [8:0] POS_SECOND = 9'd1;
	localparam logic [8:0] POS_CODE   = 9'd2;
	localparam logic [8:0] POS_SEQ    = 9'd3;
	localparam logic [8:0] POS_LENGTH = 9'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] msg_type;
		logic [3:0] resp_code;
		logic [1:0] info_code;
		logic [7:0] seq_num;
		logic       seq_valid;
		logic [7:0] payload_len;
		logic       corrupt;
	} rpd_result_t;

	function automatic logic [3:0] map_regular_code(input logic [7:0] v);
		logic [3:0] c;
		begin
			if (v <= RAW_LAST_PLAIN)          c = v[3:0];
			else if (v == RAW_APPCORRUPT)     c = CODE_APPCORRUPT;
			else if (v == RAW_TIMEOUT)        c = CODE_TIMEOUT;
			else if (v == RAW_UNKNOWN)        c = CODE_UNKNOWN;
			else if (v == RAW_UNKNOWNRESP)    c = CODE_UNKNOWNRESP;
			else                              c = CODE_INVALID;
			return c;
		end
	endfunction

	function automatic logic [1:0] map_info_code(input logic [7:0] v);
		logic [1:0] c;
		begin
			if (v == RAW_INFO_EMIT)      c = INFO_EMIT;
			else if (v == RAW_INFO_DATA) c = INFO_DATA;
			else                         c = INFO_INVALID;
			return c;
		end
	endfunction

endpackage

// ===== src/response_packet_deframer.sv =====
// Response packet deframer: one received byte per beat in, payload and summary beats out.
// Each accepted byte goes into the input register; its result (if any) is loaded into the
// result register once the byte is processed.
// Throughput: one byte per cycle while rx_stall is low; the input and result registers
// decouple the two sides, so rx_stall rises only while a held result blocks a new one.
// Reset (arst_n low, asynchronous): both registers empty, next byte is a first header byte.
module response_packet_deframer import rpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic [1:0] msg_type,
	output logic [3:0] resp_code,
	output logic [1:0] info_code,
	output logic [7:0] seq_num,
	output logic       seq_valid,
	output logic [7:0] payload_len,
	output logic       corrupt
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        has_res;
	logic        out_free;
	logic        fire;
	rpd_result_t res_next;
	rpd_result_t res_q;

	assign out_free = !res_valid || !res_stall;
	// a byte with no result never waits on the output side
	assign fire     = valid_s1 && (!has_res || out_free);
	assign rx_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	rpd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (byte_s1),
		.has_res (has_res),
		.res     (res_next)
	);

	rpd_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire && has_res),
		.res_in  (res_next),
		.stall   (res_stall),
		.valid_q (res_valid),
		.res_q   (res_q)
	);

	assign result_kind = res_q.kind;
	assign data_byte   = res_q.data;
	assign msg_type    = res_q.msg_type;
	assign resp_code   = res_q.resp_code;
	assign info_code   = res_q.info_code;
	assign seq_num     = res_q.seq_num;
	assign seq_valid   = res_q.seq_valid;
	assign payload_len = res_q.payload_len;
	assign corrupt     = res_q.corrupt;

endmodule

// ===== src/rpd_parse.sv =====
// Packet state tracking: header decode, field latching, byte count and checksum.
module rpd_parse import rpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        rx_byte,
	output logic              has_res,
	output rpd_result_t       res
);

	logic [8:0] pos_q, pos_d;
	logic [7:0] first_q, first_d;
	logic [1:0] type_q, type_d;
	logic [3:0] code_q, code_d;
	logic [1:0] info_q, info_d;
	logic [7:0] seq_q, seq_d;
	logic [7:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;
	logic [8:0] last_pos;
	logic [7:0] sum_add;
	logic [1:0] kind;
	logic [7:0] data;
	logic       corrupt;

	assign sum_add = sum_q + rx_byte;

	always_comb begin
		pos_d   = pos_q;
		first_d = first_q;
		type_d  = type_q;
		code_d  = code_q;
		info_d  = info_q;
		seq_d   = seq_q;
		len_d   = len_q;
		sum_d   = sum_q;
		has_res = 1'b0;
		kind    = KIND_PAYLOAD;
		data    = 8'd0;
		corrupt = 1'b0;
		last_pos = 9'd0;
		case (pos_q)
			POS_FIRST: begin
				first_d = rx_byte;
				sum_d   = 8'd0;
				seq_d   = 8'd0;
				len_d   = 8'd0;
				code_d  = CODE_INVALID;
				info_d  = INFO_INVALID;
				pos_d   = POS_SECOND;
			end
			POS_SECOND: begin
				if (first_q == SYNC_BYTE && rx_byte == REGULAR_BYTE) begin
					type_d = TYPE_REGULAR;
					pos_d  = POS_CODE;
				end else if (first_q == SYNC_BYTE && rx_byte == INFO_BYTE) begin
					type_d = TYPE_INFO;
					pos_d  = POS_CODE;
				end else begin
					type_d  = TYPE_UNKNOWN;
					code_d  = CODE_BADMSG;
					info_d  = INFO_INVALID;
					len_d   = 8'd0;
					has_res = 1'b1;
					kind    = KIND_BADHDR;
					corrupt = (rx_byte != 8'hFF);
					pos_d   = POS_FIRST;
				end
			end
			POS_CODE: begin
				if (type_q == TYPE_REGULAR) code_d = map_regular_code(rx_byte);
				else                        info_d = map_info_code(rx_byte);
				sum_d = sum_add;
				pos_d = POS_SEQ;
			end
			POS_SEQ: begin
				if (type_q == TYPE_REGULAR) seq_d = rx_byte;
				else code_d = (rx_byte == 8'd0) ? CODE_OK : CODE_INVALID;
				sum_d = sum_add;
				pos_d = POS_LENGTH;
			end
			default: begin
				if (pos_q == POS_LENGTH) len_d = rx_byte;
				last_pos = POS_LENGTH + {1'b0, len_d};
				if (pos_q >= last_pos) begin
					// checksum beat: close the packet
					has_res = 1'b1;
					kind    = KIND_SUMMARY;
					corrupt = (~sum_q != rx_byte);
					pos_d   = POS_FIRST;
				end else begin
					if (pos_q != POS_LENGTH) begin
						has_res = 1'b1;
						kind    = KIND_PAYLOAD;
						data    = rx_byte;
					end
					sum_d = sum_add;
					pos_d = pos_q + 9'd1;
				end
			end
		endcase
	end

	always_comb begin
		res.kind        = kind;
		res.data        = data;
		res.msg_type    = type_d;
		res.resp_code   = code_d;
		res.info_code   = info_d;
		res.seq_valid   = (type_d == TYPE_REGULAR);
		res.seq_num     = (type_d == TYPE_REGULAR) ? seq_d : 8'd0;
		res.payload_len = len_d;
		res.corrupt     = corrupt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_FIRST;
			first_q <= 8'd0;
			type_q  <= TYPE_UNKNOWN;
			code_q  <= CODE_INVALID;
			info_q  <= INFO_INVALID;
			seq_q   <= 8'd0;
			len_q   <= 8'd0;
			sum_q   <= 8'd0;
		end else if (fire) begin
			pos_q   <= pos_d;
			first_q <= first_d;
			type_q  <= type_d;
			code_q  <= code_d;
			info_q  <= info_d;
			seq_q   <= seq_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
		end
	end

endmodule

// ===== src/rpd_out_reg.sv =====
// Result register that holds a beat until the downstream side takes it.
module rpd_out_reg import rpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  rpd_result_t res_in,
	input  logic        stall,
	output logic        valid_q,
	output rpd_result_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== src/rpd_checker.sv =====
// Port-level checks for the response packet deframer, bound to the top level.
module rpd_checker import rpd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] result_kind,
	input logic [7:0] data_byte,
	input logic [1:0] msg_type,
	input logic [3:0] resp_code,
	input logic [7:0] seq_num,
	input logic       seq_valid,
	input logic [7:0] payload_len,
	input logic       corrupt
);

	// hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(result_kind) &&
			$stable(data_byte) && $stable(corrupt) && $stable(payload_len))
		else $error("stalled result beat changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (result_kind == KIND_PAYLOAD || result_kind == KIND_SUMMARY ||
			result_kind == KIND_BADHDR))
		else $error("result kind out of range");

	a_badhdr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == KIND_BADHDR |-> msg_type == TYPE_UNKNOWN &&
			resp_code == CODE_BADMSG && !seq_valid && payload_len == 8'd0 &&
			data_byte == 8'd0)
		else $error("bad header beat carries packet fields");

	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == KIND_PAYLOAD |-> !corrupt && payload_len != 8'd0 &&
			msg_type != TYPE_UNKNOWN)
		else $error("payload beat outside a known packet");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (seq_valid == (msg_type == TYPE_REGULAR)) &&
			(seq_valid || seq_num == 8'd0))
		else $error("sequence fields inconsistent with type");

endmodule

bind response_packet_deframer rpd_checker u_rpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.result_kind (result_kind),
	.data_byte   (data_byte),
	.msg_type    (msg_type),
	.resp_code   (resp_code),
	.seq_num     (seq_num),
	.seq_valid   (seq_valid),
	.payload_len (payload_len),
	.corrupt     (corrupt)
);
